// ===== rtl/sbr_pkg.sv =====
// Shared types and constants for the STX/ETX BCC reply receiver.
// No dependencies; every other file but sbr_if refers to it by scoped names.
`timescale 1ns / 1ps

package sbr_pkg;

  // Size of the reply store; the byte counter and length math follow it.
  localparam int unsigned MAX_REPLY_BYTES = 20;
  localparam int unsigned CNT_W = $clog2(MAX_REPLY_BYTES + 1);
  localparam int unsigned LEN_W = 5;
  localparam int unsigned EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Reply layout.
  localparam int unsigned NUM_DIGITS = 8;
  localparam int unsigned CMD1_IDX = 1;
  localparam int unsigned CMD2_IDX = 2;
  localparam int unsigned DIGIT_BASE = 3;
  localparam int unsigned DC_MAX = 9;
  localparam int unsigned DC_PAD = 5;
  localparam int unsigned LEN_SHORT = 11;
  localparam int unsigned LEN_LONG = 13;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NACK = 8'h15;

  localparam logic [3:0] DIGIT_COUNT_RST = 4'd8;
  localparam logic [15:0] TIMEOUT_RST = 16'd40;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_DIGIT_COUNT = 2'd0,
    REG_CMD_ONE     = 2'd1,
    REG_CMD_TWO     = 2'd2,
    REG_TIMEOUT     = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_ACK      = 3'd1,
    ST_NACK     = 3'd2,
    ST_CHECK    = 3'd3,
    ST_FORMAT   = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // Classified item as it travels through the queue.
  typedef struct packed {
    op_e        kind;
    logic [7:0] data;
    logic       is_stx;
    logic       is_etx;
    logic       is_ack;
    logic       is_nack;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  digit_count;
    logic [7:0]  cmd_one;
    logic [7:0]  cmd_two;
    logic [15:0] timeout;
  } cfg_t;

endpackage

// ===== rtl/sbr_if.sv =====
// Valid/ready channel interfaces for the reply receiver's input and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface sbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface sbr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] frame_length;
  logic [7:0] digit_a;
  logic [7:0] digit_b;
  logic [7:0] digit_c;
  logic [7:0] digit_d;
  logic [7:0] digit_e;
  logic [7:0] digit_f;
  logic [7:0] digit_g;
  logic [7:0] digit_h;

  modport source (output valid, output status, output frame_length,
                  output digit_a, output digit_b, output digit_c, output digit_d,
                  output digit_e, output digit_f, output digit_g, output digit_h,
                  input ready);
  modport sink (input valid, input status, input frame_length,
                input digit_a, input digit_b, input digit_c, input digit_d,
                input digit_e, input digit_f, input digit_g, input digit_h,
                output ready);
endinterface

// ===== rtl/sbr_front.sv =====
// Front end: accepts input items and classifies them into queue commands.
// Depends on sbr_pkg and sbr_if.
`timescale 1ns / 1ps

module sbr_front (
  sbr_in_if.sink       in_ch,
  input  logic         full_i,
  output logic         push_o,
  output sbr_pkg::cmd_t cmd_o
);

  logic known_op;

  assign in_ch.ready = !full_i;

  always_comb begin
    cmd_o.data    = in_ch.rx_byte;
    cmd_o.is_stx  = (in_ch.rx_byte == sbr_pkg::BYTE_STX);
    cmd_o.is_etx  = (in_ch.rx_byte == sbr_pkg::BYTE_ETX);
    cmd_o.is_ack  = (in_ch.rx_byte == sbr_pkg::BYTE_ACK);
    cmd_o.is_nack = (in_ch.rx_byte == sbr_pkg::BYTE_NACK);
    known_op      = 1'b1;
    cmd_o.kind    = sbr_pkg::OP_START;
    unique case (in_ch.op)
      sbr_pkg::OP_START: cmd_o.kind = sbr_pkg::OP_START;
      sbr_pkg::OP_BYTE:  cmd_o.kind = sbr_pkg::OP_BYTE;
      sbr_pkg::OP_TICK:  cmd_o.kind = sbr_pkg::OP_TICK;
      default:           known_op = 1'b0;  // drop the unused code
    endcase
  end

  assign push_o = in_ch.valid && !full_i && known_op;

endmodule

// ===== rtl/sbr_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on sbr_pkg.
`timescale 1ns / 1ps

module sbr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sbr_pkg::cmd_t cmd_o
);

  sbr_pkg::cmd_t                   mem_q [sbr_pkg::QUEUE_DEPTH];
  logic [sbr_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sbr_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == sbr_pkg::QCNT_W'(sbr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sbr_pkg::QPTR_W'(sbr_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + sbr_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sbr_pkg::QPTR_W'(sbr_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + sbr_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + sbr_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - sbr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/sbr_back.sv =====
// Back end: runs the reply state, judges finished replies, holds the result register.
// Depends on sbr_pkg and sbr_if.
`timescale 1ns / 1ps

module sbr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbr_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  sbr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  sbr_out_if.source     out_ch
);

  localparam int unsigned CW = sbr_pkg::CNT_W;
  localparam int unsigned XW = sbr_pkg::EXT_W;

  // Reply state.
  logic          armed_q, armed_d;
  logic          seen_start_q, seen_start_d;
  logic          seen_end_q, seen_end_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    chk_q, chk_d;
  logic [15:0]   ticks_q, ticks_d;

  // Stored reply bytes that are read back: command pair and data digits.
  logic [7:0]    cmd1_q, cmd2_q;
  logic [7:0]    digits_q [sbr_pkg::NUM_DIGITS];

  // Result register.
  logic                         out_valid_q;
  sbr_pkg::status_e             status_q;
  logic [sbr_pkg::LEN_W-1:0]    len_q;
  logic [7:0]                   dig_q [sbr_pkg::NUM_DIGITS];

  logic                 emit, store_en, with_dig, start_ok, fin, lone;
  sbr_pkg::status_e     status_n;
  logic [CW-1:0]        cnt_inc, len_cnt;
  logic [XW-1:0]        n_ext, dc_ext, len_ext;

  assign cnt_inc = cnt_q + CW'(1);
  assign n_ext   = XW'(cnt_inc);
  assign dc_ext  = XW'(cfg_i.digit_count) + XW'(sbr_pkg::DC_PAD);
  assign len_ext = XW'(len_cnt);

  always_comb begin
    armed_d      = armed_q;
    seen_start_d = seen_start_q;
    seen_end_d   = seen_end_q;
    cnt_d        = cnt_q;
    chk_d        = chk_q;
    ticks_d      = ticks_q;
    emit         = 1'b0;
    store_en     = 1'b0;
    with_dig     = 1'b0;
    status_n     = sbr_pkg::ST_DATA;
    len_cnt      = cnt_q;
    start_ok     = seen_start_q || cmd_i.is_stx || cmd_i.is_ack || cmd_i.is_nack;
    fin          = seen_end_q || (!seen_start_q && (cmd_i.is_ack || cmd_i.is_nack));
    lone         = (cnt_q == '0) && (cmd_i.is_ack || cmd_i.is_nack);
    unique case (cmd_i.kind)
      sbr_pkg::OP_START: begin
        armed_d      = 1'b1;
        seen_start_d = 1'b0;
        seen_end_d   = 1'b0;
        cnt_d        = '0;
        chk_d        = '0;
        ticks_d      = '0;
      end
      sbr_pkg::OP_TICK: begin
        if (armed_q) begin
          if (ticks_q >= cfg_i.timeout) begin
            emit     = 1'b1;
            status_n = sbr_pkg::ST_TIMEOUT;
            len_cnt  = cnt_q;
            armed_d  = 1'b0;
          end else begin
            ticks_d = ticks_q + 16'd1;
          end
        end
      end
      sbr_pkg::OP_BYTE: begin
        if (armed_q && start_ok) begin
          seen_start_d = 1'b1;
          if (cnt_q >= CW'(sbr_pkg::MAX_REPLY_BYTES)) begin
            emit     = 1'b1;
            status_n = sbr_pkg::ST_OVERFLOW;
            len_cnt  = CW'(sbr_pkg::MAX_REPLY_BYTES);
            armed_d  = 1'b0;
          end else begin
            store_en = 1'b1;
            cnt_d    = cnt_inc;
            if (!fin && (cnt_q != '0)) begin
              chk_d = chk_q ^ cmd_i.data;
            end
            if (cnt_inc >= CW'(sbr_pkg::MAX_REPLY_BYTES)) begin
              emit     = 1'b1;
              status_n = sbr_pkg::ST_OVERFLOW;
              len_cnt  = CW'(sbr_pkg::MAX_REPLY_BYTES);
              armed_d  = 1'b0;
            end else if (!fin) begin
              seen_end_d = cmd_i.is_etx;
            end else begin
              emit    = 1'b1;
              len_cnt = cnt_inc;
              armed_d = 1'b0;
              // Judge in order: length and check byte, digit count, lone ACK/NACK, frame fit.
              priority if (!lone && !((n_ext == XW'(sbr_pkg::LEN_SHORT)) ||
                                      (n_ext == XW'(sbr_pkg::LEN_LONG)) ) ) begin
                status_n = sbr_pkg::ST_CHECK;
              end else if (!lone && (chk_q != cmd_i.data)) begin
                status_n = sbr_pkg::ST_CHECK;
              end else if ((cfg_i.digit_count == 4'd0) ||
                           (cfg_i.digit_count > 4'(sbr_pkg::DC_MAX))) begin
                status_n = sbr_pkg::ST_FORMAT;
              end else if (lone) begin
                status_n = cmd_i.is_nack ? sbr_pkg::ST_NACK : sbr_pkg::ST_ACK;
              end else if (n_ext != dc_ext) begin
                status_n = sbr_pkg::ST_FORMAT;
              end else if ((cmd1_q != cfg_i.cmd_one) || (cmd2_q != cfg_i.cmd_two)) begin
                status_n = sbr_pkg::ST_FORMAT;
              end else begin
                status_n = sbr_pkg::ST_DATA;
                with_dig = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Take a command unless it produces a result while the result register is held.
  assign cmd_pop_o = cmd_valid_i && (!emit || !out_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b0;
      seen_start_q <= 1'b0;
      seen_end_q   <= 1'b0;
      cnt_q        <= '0;
      chk_q        <= '0;
      ticks_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        armed_q      <= armed_d;
        seen_start_q <= seen_start_d;
        seen_end_q   <= seen_end_d;
        cnt_q        <= cnt_d;
        chk_q        <= chk_d;
        ticks_q      <= ticks_d;
      end
      if (cmd_pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store bytes at the fixed places that are read back.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && store_en) begin
      if (cnt_q == CW'(sbr_pkg::CMD1_IDX)) begin
        cmd1_q <= cmd_i.data;
      end
      if (cnt_q == CW'(sbr_pkg::CMD2_IDX)) begin
        cmd2_q <= cmd_i.data;
      end
      for (int k = 0; k < sbr_pkg::NUM_DIGITS; k++) begin
        if (cnt_q == CW'(sbr_pkg::DIGIT_BASE + k)) begin
          digits_q[k] <= cmd_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && emit) begin
      status_q <= status_n;
      len_q    <= len_ext[sbr_pkg::LEN_W-1:0];
      for (int k = 0; k < sbr_pkg::NUM_DIGITS; k++) begin
        dig_q[k] <= (with_dig && (4'(k) < cfg_i.digit_count)) ? digits_q[k] : 8'd0;
      end
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = status_q;
  assign out_ch.frame_length = len_q;
  assign out_ch.digit_a      = dig_q[0];
  assign out_ch.digit_b      = dig_q[1];
  assign out_ch.digit_c      = dig_q[2];
  assign out_ch.digit_d      = dig_q[3];
  assign out_ch.digit_e      = dig_q[4];
  assign out_ch.digit_f      = dig_q[5];
  assign out_ch.digit_g      = dig_q[6];
  assign out_ch.digit_h      = dig_q[7];

endmodule

// ===== rtl/stx_etx_bcc_reply_receiver.sv =====
// Top level of the STX/ETX reply receiver: configuration registers and the
// front end, command queue and back end. Depends on sbr_pkg, sbr_if and the sbr_* modules.
`timescale 1ns / 1ps

// The receiver takes one item per clock cycle on in_ch (start, received byte
// or tick) while its command queue is not full, and sends one result item on
// out_ch when a reply finishes: a lone ACK/NACK, a framed reply closed by its
// check byte, a timeout on a tick, or a full store. An item is classified in
// the front end and written into a two-entry command queue at the edge that
// accepts it; the back end takes it from the queue and loads the result
// register. The sustained rate is one item per cycle, set by the back end,
// which retires one queue entry a cycle; while a result waits in the output
// register, items that cause no result keep flowing and only an item that
// would produce a second result holds the queue. Registers sit on the APB
// port at byte addresses 0 (digit count), 4 and 8 (command pair) and 12
// (timeout ticks); pready is always high, and writes belong to idle periods.
module stx_etx_bcc_reply_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sbr_in_if.sink                       in_ch,
  sbr_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbr_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbr_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  sbr_pkg::cfg_t  cfg_q;
  sbr_pkg::cmd_t  push_cmd, pop_cmd;
  sbr_pkg::reg_e  reg_sel;
  logic           push, full, pop, pending, cfg_wr;

  // Configuration registers: word index from paddr, written on the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = sbr_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_count <= sbr_pkg::DIGIT_COUNT_RST;
      cfg_q.cmd_one     <= '0;
      cfg_q.cmd_two     <= '0;
      cfg_q.timeout     <= sbr_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        sbr_pkg::REG_DIGIT_COUNT: cfg_q.digit_count <= pwdata[3:0];
        sbr_pkg::REG_CMD_ONE:     cfg_q.cmd_one     <= pwdata[7:0];
        sbr_pkg::REG_CMD_TWO:     cfg_q.cmd_two     <= pwdata[7:0];
        sbr_pkg::REG_TIMEOUT:     cfg_q.timeout     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      sbr_pkg::REG_DIGIT_COUNT: prdata = sbr_pkg::PDATA_W'(cfg_q.digit_count);
      sbr_pkg::REG_CMD_ONE:     prdata = sbr_pkg::PDATA_W'(cfg_q.cmd_one);
      sbr_pkg::REG_CMD_TWO:     prdata = sbr_pkg::PDATA_W'(cfg_q.cmd_two);
      sbr_pkg::REG_TIMEOUT:     prdata = sbr_pkg::PDATA_W'(cfg_q.timeout);
      default: ;
    endcase
  end

  // Classify items; drop the unused op code here.
  sbr_front u_front (
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // Hold classified items so the two sides stall independently.
  sbr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (pending),
    .cmd_o   (pop_cmd)
  );

  // Advance the reply state and register results.
  sbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pending),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== rtl/sbr_checker.sv =====
// Port-level checks on the reply receiver's result channel, bound to the top level.
// Depends on sbr_pkg and stx_etx_bcc_reply_receiver.
`timescale 1ns / 1ps

module sbr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] status_i,
  input logic [4:0] frame_length_i,
  input logic [7:0] digit_a_i,
  input logic [7:0] digit_b_i,
  input logic [7:0] digit_c_i,
  input logic [7:0] digit_d_i,
  input logic [7:0] digit_e_i,
  input logic [7:0] digit_f_i,
  input logic [7:0] digit_g_i,
  input logic [7:0] digit_h_i
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(frame_length_i))
    else $error("result changed while stalled");

  // Digits come only with a good data reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != sbr_pkg::ST_DATA) |->
      (digit_a_i == 8'd0) && (digit_b_i == 8'd0) && (digit_c_i == 8'd0) &&
      (digit_d_i == 8'd0) && (digit_e_i == 8'd0) && (digit_f_i == 8'd0) &&
      (digit_g_i == 8'd0) && (digit_h_i == 8'd0))
    else $error("digits present without data status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == sbr_pkg::ST_ACK) || (status_i == sbr_pkg::ST_NACK)) |->
      (frame_length_i == 5'd1))
    else $error("ack or nack reply longer than one byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == sbr_pkg::ST_DATA) |->
      (frame_length_i == 5'(sbr_pkg::LEN_SHORT)) || (frame_length_i == 5'(sbr_pkg::LEN_LONG)))
    else $error("data reply with bad length");

endmodule

bind stx_etx_bcc_reply_receiver sbr_checker u_sbr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .status_i       (out_ch.status),
  .frame_length_i (out_ch.frame_length),
  .digit_a_i      (out_ch.digit_a),
  .digit_b_i      (out_ch.digit_b),
  .digit_c_i      (out_ch.digit_c),
  .digit_d_i      (out_ch.digit_d),
  .digit_e_i      (out_ch.digit_e),
  .digit_f_i      (out_ch.digit_f),
  .digit_g_i      (out_ch.digit_g),
  .digit_h_i      (out_ch.digit_h)
);
